### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Command and result codes shared by the point-in-polygon classifier.
// ----------------------------------------------------------------------------
package pip_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] loc_t;

  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  localparam loc_t LOC_OUTSIDE = 2'd0;
  localparam loc_t LOC_INSIDE  = 2'd1;
  localparam loc_t LOC_ON_EDGE = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

endpackage

### rtl/pip_in_if.sv
// ----------------------------------------------------------------------------
// pip_in_if
// Command channel: clear, append vertex or query point.
// ----------------------------------------------------------------------------
interface pip_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  pip_pkg::cmd_t                cmd;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, cmd, coord_x, coord_y, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, output ready);
endinterface

### rtl/pip_out_if.sv
// ----------------------------------------------------------------------------
// pip_out_if
// Result channel: status, location and vertex count per command.
// ----------------------------------------------------------------------------
interface pip_out_if #(
  parameter int COUNT_BITS = 7
);
  logic                  valid;
  logic                  ready;
  logic                  status;
  pip_pkg::loc_t         location;
  logic [COUNT_BITS-1:0] count_now;

  modport source (output valid, status, location, count_now, input ready);
  modport sink   (input valid, status, location, count_now, output ready);
endinterface

### rtl/pip_edge_cell.sv
// ----------------------------------------------------------------------------
// pip_edge_cell
// One polygon edge: holds vertex I and its successor, tests the passing
// query point against the edge in two stages (products, then sums/compares).
// ----------------------------------------------------------------------------
module pip_edge_cell #(
  parameter int I          = 0,
  parameter int COORD_BITS = 16,
  parameter int NW         = 7
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic prev_valid,
  input  logic [4*COORD_BITS+2*NW+4:0] prev_item,
  output logic fwd_valid,
  output logic [4*COORD_BITS+2*NW+4:0] fwd_item
);
  import pip_pkg::*;

  localparam int C = COORD_BITS;
  localparam int D = C + 1;
  localparam int P = 2 * D;
  localparam int S = P + 1;

  typedef struct packed {
    logic                query;
    logic                append;
    logic [NW-1:0]       cnt;
    logic [NW-1:0]       count_now;
    logic                status;
    logic signed [C-1:0] x;
    logic signed [C-1:0] y;
    logic signed [C-1:0] v0x;
    logic signed [C-1:0] v0y;
    logic                on_edge;
    logic                odd;
  } item_t;

  item_t in_item;
  item_t s1_item;
  item_t s1_item_next;
  item_t s2_item;
  item_t s2_item_next;

  logic signed [C-1:0] vx;
  logic signed [C-1:0] vy;
  logic signed [C-1:0] nx;
  logic signed [C-1:0] ny;
  logic signed [C-1:0] v0x_use;
  logic signed [C-1:0] v0y_use;
  logic signed [C-1:0] ex;
  logic signed [C-1:0] ey;
  logic                is_last;

  logic signed [D-1:0] ax, ay, bx, by, dy;
  logic signed [P-1:0] m0, m1, m2, m3;
  logic signed [D-1:0] s1_ay;
  logic signed [D-1:0] s1_dy;
  logic                s1_valid;
  logic                s1_active;

  logic signed [S-1:0] cr;
  logic signed [S-1:0] dt;
  logic signed [D:0]   dy_ay;
  logic                hit;
  logic                on_here;

  assign in_item = item_t'(prev_item);

  // stage 1: differences and products
  always_comb begin
    v0x_use = (I == 0) ? vx : in_item.v0x;
    v0y_use = (I == 0) ? vy : in_item.v0y;
    is_last = (in_item.cnt == NW'(I + 1));
    ex      = is_last ? v0x_use : nx;
    ey      = is_last ? v0y_use : ny;
    ax      = D'(vx) - D'(in_item.x);
    ay      = D'(vy) - D'(in_item.y);
    bx      = D'(in_item.x) - D'(ex);
    by      = D'(in_item.y) - D'(ey);
    dy      = D'(ey) - D'(vy);
    s1_item_next     = in_item;
    s1_item_next.v0x = v0x_use;
    s1_item_next.v0y = v0y_use;
  end

  always_ff @(posedge clk) begin
    if (advance && prev_valid && in_item.append) begin
      if (in_item.cnt == NW'(I)) begin
        vx <= in_item.x;
        vy <= in_item.y;
      end
      if (in_item.cnt == NW'(I + 1)) begin
        nx <= in_item.x;
        ny <= in_item.y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item     <= s1_item_next;
      s1_active   <= in_item.query && (NW'(I) < in_item.cnt);
      m0          <= P'(ax) * P'(by);
      m1          <= P'(ay) * P'(bx);
      m2          <= P'(ax) * P'(bx);
      m3          <= P'(ay) * P'(by);
      s1_ay       <= ay;
      s1_dy       <= dy;
    end
  end

  // stage 2: cross and dot products, half-open crossing rule
  always_comb begin
    cr      = S'(m0) - S'(m1);
    dt      = S'(m2) + S'(m3);
    dy_ay   = (D + 1)'(s1_dy) + (D + 1)'(s1_ay);
    on_here = (cr == '0) && !dt[S-1];
    if (s1_dy > 0) begin
      hit = (s1_ay <= 0) && (dy_ay > 0) && cr[S-1];
    end else begin
      hit = (dy_ay <= 0) && (s1_ay > 0) && !cr[S-1] && (cr != '0);
    end
    s2_item_next = s1_item;
    if (s1_active) begin
      s2_item_next.on_edge = s1_item.on_edge | on_here;
      s2_item_next.odd     = s1_item.odd ^ hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (advance) begin
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_item <= s2_item_next;
    end
  end

  assign fwd_item = s2_item;

endmodule

### rtl/point_in_polygon_classifier.sv
// ----------------------------------------------------------------------------
// point_in_polygon_classifier
// Crossing-number point-in-polygon test over a chain of per-edge cells.
//
//   channel  dir  payload                      transaction
//   in       in   cmd, coord_x, coord_y        valid & ready
//   out      out  status, location, count_now  valid & ready
//
// One transaction enters per cycle while the chain is not stalled; results
// leave in order after the front register, two stages per edge cell and the
// output register. Reset empties the vertex table and drops work in flight.
// The chain stalls only while its last stage and the output register are
// both full and out is not ready; a bubble at the end lets input keep flowing.
// ----------------------------------------------------------------------------
module point_in_polygon_classifier #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input logic clk,
  input logic rst,
  pip_in_if.sink    in,
  pip_out_if.source out
);
  import pip_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int IW = 4 * C + 2 * NW + 5;

  typedef struct packed {
    logic                query;
    logic                append;
    logic [NW-1:0]       cnt;
    logic [NW-1:0]       count_now;
    logic                status;
    logic signed [C-1:0] x;
    logic signed [C-1:0] y;
    logic signed [C-1:0] v0x;
    logic signed [C-1:0] v0y;
    logic                on_edge;
    logic                odd;
  } item_t;

  logic [NW-1:0] total;
  logic [NW-1:0] total_next;
  logic          full;
  logic          accept;
  logic          advance;
  item_t         front;
  item_t         front_next;
  logic          front_valid;
  item_t         tail;
  logic [IW-1:0] link [MAX_VERTICES+1];
  logic          link_valid [MAX_VERTICES+1];

  assign full    = (total == NW'(MAX_VERTICES));
  assign advance = !link_valid[MAX_VERTICES] || !out.valid || out.ready;
  assign in.ready = advance;
  assign accept  = in.valid && advance;

  always_comb begin
    total_next           = total;
    front_next           = '0;
    front_next.cnt       = total;
    front_next.x         = in.coord_x;
    front_next.y         = in.coord_y;
    front_next.status    = STATUS_OK;
    unique case (in.cmd)
      CMD_CLEAR: begin
        total_next = '0;
      end
      CMD_APPEND: begin
        if (full) begin
          front_next.status = STATUS_DROPPED;
        end else begin
          front_next.append = 1'b1;
          total_next        = total + 1'b1;
        end
      end
      CMD_QUERY: begin
        front_next.query = 1'b1;
      end
      default: begin
      end
    endcase
    front_next.count_now = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total       <= '0;
      front_valid <= 1'b0;
    end else if (advance) begin
      front_valid <= in.valid;
      if (in.valid) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front <= front_next;
    end
  end

  assign link[0]       = front;
  assign link_valid[0] = front_valid;

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    pip_edge_cell #(
      .I          (g),
      .COORD_BITS (C),
      .NW         (NW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .prev_valid (link_valid[g]),
      .prev_item  (link[g]),
      .fwd_valid  (link_valid[g+1]),
      .fwd_item   (link[g+1])
    );
  end

  assign tail = item_t'(link[MAX_VERTICES]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (!out.valid || out.ready) begin
      out.valid <= link_valid[MAX_VERTICES];
    end
  end

  always_ff @(posedge clk) begin
    if (!out.valid || out.ready) begin
      out.status    <= tail.status;
      out.count_now <= tail.count_now;
      if (tail.query && tail.cnt != '0) begin
        out.location <= tail.on_edge ? LOC_ON_EDGE :
                        (tail.odd ? LOC_INSIDE : LOC_OUTSIDE);
      end else begin
        out.location <= LOC_OUTSIDE;
      end
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for point_in_polygon_classifier. The stimulus is a short
// hand-written list followed by random polygons (tiny lattices, local
// shapes, full-range shapes, overflowing tables) with queries aimed at
// vertices, edges, vertex rows and open space. The sender runs in bursts
// and the receiver stalls on its own pattern. A behavioral copy of the
// classifier predicts every result, and the monitor compares each one in
// order.
// ----------------------------------------------------------------------------
module tb;
  import pip_pkg::*;

  localparam int MAX_VERTICES   = 64;
  localparam int COORD_BITS     = 16;
  localparam int COUNT_BITS     = 7;
  localparam int LATENCY        = 2 * MAX_VERTICES + 2;
  localparam int RANDOM_ITEMS   = 780;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT        = 250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;

  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    cmd_t   cmd;
    coord_t x;
    coord_t y;
    bit     drain;
  } pip_cmd_t;

  typedef struct {
    logic                  status;
    loc_t                  location;
    logic [COUNT_BITS-1:0] count_now;
  } pip_verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pip_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  pip_out_if #(.COUNT_BITS(COUNT_BITS)) out_ch ();

  logic   drv_valid  = 1'b0;
  cmd_t   drv_cmd    = CMD_CLEAR;
  coord_t drv_x      = '0;
  coord_t drv_y      = '0;
  logic   sink_ready = 1'b0;

  assign in_ch.valid   = drv_valid;
  assign in_ch.cmd     = drv_cmd;
  assign in_ch.coord_x = drv_x;
  assign in_ch.coord_y = drv_y;
  assign out_ch.ready  = sink_ready;

  point_in_polygon_classifier #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in (in_ch),
    .out(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pip_cmd_t     cmd_backlog[$];
  pip_verdict_t pending_verdicts[$];

  longint poly_x[MAX_VERTICES];
  longint poly_y[MAX_VERTICES];
  int     poly_count = 0;

  int errors        = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_queries     = 0;
  int n_inside      = 0;
  int n_on_edge     = 0;
  int n_dropped     = 0;
  int n_unused      = 0;
  int stuck_cycles  = 0;

  // Behavioral classifier -----------------------------------------------------

  function automatic loc_t point_location(longint px, longint py);
    int     i;
    int     j;
    longint ax, ay, bx, by, dx, dy, cr, dt;
    bit     odd;
    bit     hit;
    odd = 1'b0;
    if (poly_count == 0) return LOC_OUTSIDE;
    for (i = 0; i < poly_count; i++) begin
      j = (i + 1 == poly_count) ? 0 : i + 1;
      ax = poly_x[i] - px;
      ay = poly_y[i] - py;
      bx = px - poly_x[j];
      by = py - poly_y[j];
      cr = ax * by - ay * bx;
      dt = ax * bx + ay * by;
      if (cr == 0 && dt >= 0) return LOC_ON_EDGE;
    end
    for (i = 0; i < poly_count; i++) begin
      j = (i + 1 == poly_count) ? 0 : i + 1;
      dx = poly_x[j] - poly_x[i];
      dy = poly_y[j] - poly_y[i];
      ax = px - poly_x[i];
      ay = py - poly_y[i];
      cr = ax * dy - ay * dx;
      if (dy > 0) hit = (ay >= 0) && (ay < dy) && (cr < 0);
      else        hit = (dy <= ay) && (ay < 0) && (cr > 0);
      if (hit) odd = !odd;
    end
    return odd ? LOC_INSIDE : LOC_OUTSIDE;
  endfunction

  function automatic pip_verdict_t classify_command(pip_cmd_t c);
    pip_verdict_t v;
    v.status   = STATUS_OK;
    v.location = LOC_OUTSIDE;
    case (c.cmd)
      CMD_CLEAR: poly_count = 0;
      CMD_APPEND: begin
        if (poly_count >= MAX_VERTICES) begin
          v.status = STATUS_DROPPED;
          n_dropped++;
        end else begin
          poly_x[poly_count] = c.x;
          poly_y[poly_count] = c.y;
          poly_count++;
        end
      end
      CMD_QUERY: begin
        v.location = point_location(c.x, c.y);
        n_queries++;
        if (v.location == LOC_INSIDE) n_inside++;
        if (v.location == LOC_ON_EDGE) n_on_edge++;
      end
      default: n_unused++;
    endcase
    v.count_now = COUNT_BITS'(poly_count);
    return v;
  endfunction

  // Stimulus helpers ----------------------------------------------------------

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return int'(v);
  endfunction

  function automatic void push_cmd(cmd_t c, int x, int y, bit drain = 1'b0);
    pip_cmd_t it;
    it.cmd   = c;
    it.x     = coord_t'(x);
    it.y     = coord_t'(y);
    it.drain = drain;
    cmd_backlog.insert(cmd_backlog.size(), it);
  endfunction

  function automatic void add_random_polygon(int nverts, bit drain);
    int vx[$];
    int vy[$];
    int mode, cx, cy, rad, nq, k, i, j, pick, x, y;
    int xmin, xmax, ymin, ymax;
    mode = $urandom_range(0, 99);
    cx = rand_between(COORD_MIN, COORD_MAX);
    cy = rand_between(COORD_MIN, COORD_MAX);
    rad = rand_between(2, 300);
    push_cmd(CMD_CLEAR, rand_between(COORD_MIN, COORD_MAX),
             rand_between(COORD_MIN, COORD_MAX), drain);
    if ($urandom_range(0, 9) == 0)
      push_cmd(CMD_QUERY, rand_between(COORD_MIN, COORD_MAX),
               rand_between(COORD_MIN, COORD_MAX));
    for (k = 0; k < nverts; k++) begin
      if (mode < 20) begin
        x = rand_between(-4, 4);
        y = rand_between(-4, 4);
      end else if (mode < 35) begin
        x = rand_between(COORD_MIN, COORD_MAX);
        y = rand_between(COORD_MIN, COORD_MAX);
      end else begin
        x = clamp_coord(longint'(cx) + rand_between(-rad, rad));
        y = clamp_coord(longint'(cy) + rand_between(-rad, rad));
      end
      push_cmd(CMD_APPEND, x, y);
      if (vx.size() < MAX_VERTICES) begin
        vx.insert(vx.size(), x);
        vy.insert(vy.size(), y);
      end
    end
    xmin = COORD_MAX; xmax = COORD_MIN; ymin = COORD_MAX; ymax = COORD_MIN;
    foreach (vx[n]) begin
      if (vx[n] < xmin) xmin = vx[n];
      if (vx[n] > xmax) xmax = vx[n];
      if (vy[n] < ymin) ymin = vy[n];
      if (vy[n] > ymax) ymax = vy[n];
    end
    if (vx.size() == 0) begin
      xmin = COORD_MIN; xmax = COORD_MAX; ymin = COORD_MIN; ymax = COORD_MAX;
    end
    xmin = clamp_coord(longint'(xmin) - 2);
    xmax = clamp_coord(longint'(xmax) + 2);
    ymin = clamp_coord(longint'(ymin) - 2);
    ymax = clamp_coord(longint'(ymax) + 2);
    nq = rand_between(8, 30);
    for (k = 0; k < nq; k++) begin
      pick = $urandom_range(0, 99);
      i = (vx.size() > 0) ? $urandom_range(0, vx.size() - 1) : 0;
      j = (i + 1 >= vx.size()) ? 0 : i + 1;
      x = rand_between(xmin, xmax);
      y = rand_between(ymin, ymax);
      if (vx.size() > 0 && pick >= 35 && pick < 50) begin
        x = vx[i];
        y = vy[i];
      end else if (vx.size() > 0 && pick >= 50 && pick < 65) begin
        if (((vx[j] - vx[i]) % 2 == 0) && ((vy[j] - vy[i]) % 2 == 0)) begin
          x = (vx[i] + vx[j]) / 2;
          y = (vy[i] + vy[j]) / 2;
        end else begin
          x = vx[j];
          y = vy[j];
        end
      end else if (vx.size() > 0 && pick >= 65 && pick < 75) begin
        y = vy[i];
      end else if (pick >= 75 && pick < 90) begin
        x = rand_between(COORD_MIN, COORD_MAX);
        y = rand_between(COORD_MIN, COORD_MAX);
      end else if (pick >= 90) begin
        push_cmd(CMD_UNUSED, rand_between(COORD_MIN, COORD_MAX),
                 rand_between(COORD_MIN, COORD_MAX));
        continue;
      end
      push_cmd(CMD_QUERY, x, y);
    end
  endfunction

  // Driver ----------------------------------------------------------------------

  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    pip_cmd_t cur;
    logic     next_valid;
    if (rst) begin
      drv_valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        cur.cmd = drv_cmd;
        cur.x   = drv_x;
        cur.y   = drv_y;
        pending_verdicts.insert(pending_verdicts.size(), classify_command(cur));
        n_sent++;
      end
      if (!drv_valid || in_ch.ready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0 &&
                     (!cmd_backlog[0].drain || pending_verdicts.size() == 0)) begin
          cur = cmd_backlog.pop_front();
          drv_cmd <= cur.cmd;
          drv_x   <= cur.x;
          drv_y   <= cur.y;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = rand_between(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : rand_between(1, 6);
          end
        end
        drv_valid <= next_valid;
      end
    end
  end

  // Receiver ------------------------------------------------------------------

  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  pat_mode  = 0;
  int  pat_left  = 0;

  always @(posedge clk) begin
    logic r;
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      if (!hold_done && n_checked >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = rand_between(16, 96);
        end else begin
          pat_left--;
        end
        case (pat_mode)
          0: r = 1'b1;
          1: r = $urandom_range(0, 1);
          2: r = ($urandom_range(0, 3) == 0);
          default: r = ((pat_left % 8) < 5);
        endcase
      end
      sink_ready <= r;
    end
  end

  // Monitor -------------------------------------------------------------------

  always @(posedge clk) begin
    pip_verdict_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected transaction status=%0d location=%0d count_now=%0d",
                 $time, out_ch.status, out_ch.location, out_ch.count_now);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, out_ch.status);
          errors++;
        end
        if (out_ch.location !== want.location) begin
          $display("%0t: location mismatch, expected %0d actual %0d",
                   $time, want.location, out_ch.location);
          errors++;
        end
        if (out_ch.count_now !== want.count_now) begin
          $display("%0t: count_now mismatch, expected %0d actual %0d",
                   $time, want.count_now, out_ch.count_now);
          errors++;
        end
        n_checked++;
      end
    end
  end

  // Watchdog ------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, pending_verdicts.size());
    $display("point_in_polygon_classifier regression: fail");
    $finish;
  end

  // Sequence ------------------------------------------------------------------

  initial begin
    int  base;
    bit  mid_drain;
    mid_drain = 1'b0;

    push_cmd(CMD_QUERY, 0, 0);
    push_cmd(CMD_UNUSED, COORD_MAX, COORD_MIN);
    push_cmd(CMD_APPEND, COORD_MIN, COORD_MIN);
    push_cmd(CMD_QUERY, COORD_MIN, COORD_MIN);
    push_cmd(CMD_QUERY, COORD_MAX, COORD_MAX);
    push_cmd(CMD_CLEAR, 0, 0);
    push_cmd(CMD_APPEND, COORD_MIN, COORD_MIN);
    push_cmd(CMD_APPEND, COORD_MAX, COORD_MIN);
    push_cmd(CMD_APPEND, COORD_MAX, COORD_MAX);
    push_cmd(CMD_APPEND, COORD_MIN, COORD_MAX);
    push_cmd(CMD_QUERY, 0, 0);
    push_cmd(CMD_QUERY, COORD_MAX, 0);
    push_cmd(CMD_QUERY, COORD_MIN, COORD_MIN);
    push_cmd(CMD_QUERY, 0, COORD_MIN);
    push_cmd(CMD_UNUSED, -1, -1);
    push_cmd(CMD_CLEAR, COORD_MIN, COORD_MAX);
    push_cmd(CMD_APPEND, 0, 0);
    push_cmd(CMD_APPEND, 8, 0);
    push_cmd(CMD_APPEND, 4, 8);
    push_cmd(CMD_QUERY, 4, 3);
    push_cmd(CMD_QUERY, 4, 0);
    push_cmd(CMD_QUERY, 12, 0);
    push_cmd(CMD_QUERY, -5, 8);

    // full table first, so that dropped appends show up early
    add_random_polygon(MAX_VERTICES + 2, 1'b1);
    base = cmd_backlog.size();
    while (cmd_backlog.size() < base + RANDOM_ITEMS) begin
      int pick;
      int nv;
      pick = $urandom_range(0, 99);
      if (pick < 5)       nv = rand_between(1, 2);
      else if (pick < 80) nv = rand_between(3, 10);
      else if (pick < 92) nv = rand_between(11, MAX_VERTICES - 1);
      else                nv = rand_between(MAX_VERTICES, MAX_VERTICES + 6);
      add_random_polygon(nv, !mid_drain && cmd_backlog.size() > base + RANDOM_ITEMS / 2);
      if (cmd_backlog.size() > base + RANDOM_ITEMS / 2) mid_drain = 1'b1;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() > 0 || drv_valid || pending_verdicts.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("%0d transactions in, %0d checked: %0d queries (%0d inside, %0d on edge)",
             n_sent, n_checked, n_queries, n_inside, n_on_edge);
    $display("%0d appends dropped on a full table, %0d unused commands",
             n_dropped, n_unused);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("point_in_polygon_classifier regression: pass");
    end else begin
      $display("point_in_polygon_classifier regression: fail");
    end
    $finish;
  end

endmodule
